// ===== sv/lvp_pkg.sv =====
// Shared types and constants for the low voltage protector.
// Used by lvp_prot and low_voltage_protector_unit.
package lvp_pkg;

  localparam logic [1:0] MODE_NORMAL      = 2'd0;
  localparam logic [1:0] MODE_WARNING     = 2'd1;
  localparam logic [1:0] MODE_TRIPPED     = 2'd2;
  localparam logic [1:0] MODE_UNAVAILABLE = 2'd3;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  localparam logic [2:0] CFG_WINDOW            = 3'd0;
  localparam logic [2:0] CFG_STOP_THRESHOLD    = 3'd1;
  localparam logic [2:0] CFG_WARN_THRESHOLD    = 3'd2;
  localparam logic [2:0] CFG_RECOVER_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_STOP_DURATION     = 3'd4;
  localparam logic [2:0] CFG_MISSING_DURATION  = 3'd5;
  localparam logic [2:0] CFG_LATCH_TRIP        = 3'd6;

  localparam logic [5:0]         RST_WINDOW            = 6'd8;
  localparam logic signed [15:0] RST_STOP_THRESHOLD    = 16'sd3300;
  localparam logic signed [15:0] RST_WARN_THRESHOLD    = 16'sd3500;
  localparam logic signed [15:0] RST_RECOVER_THRESHOLD = 16'sd3600;
  localparam logic [31:0]        RST_STOP_DURATION     = 32'd1000;
  localparam logic [31:0]        RST_MISSING_DURATION  = 32'd1000;
  localparam logic               RST_LATCH_TRIP        = 1'b1;

  typedef struct packed {
    logic signed [15:0] stop_threshold_mv;
    logic signed [15:0] warn_threshold_mv;
    logic signed [15:0] recover_threshold_mv;
    logic [31:0]        stop_dur_ms;
    logic [31:0]        missing_duration_ms;
    logic               latch_trip;
  } prot_cfg_t;

  typedef struct packed {
    logic               update;
    logic               operation;
    logic               sample_valid;
    logic [31:0]        now_ms;
    logic               have_avg;
    logic signed [15:0] avg_mv;
  } prot_req_t;

endpackage

// ===== sv/low_voltage_protector_unit.sv =====
// Top level of the low voltage protector: sequencer, sample ring and registers.
// Depends on lvp_pkg, lvp_div and lvp_prot.
//
// Use: present a request on in_valid with operation, sample_valid, sample_mv
// and now_ms; it is taken at a clock edge with in_valid high and in_stall low.
// Every request gives exactly one result (protect_state, average_mv,
// average_valid) on out_valid, held until a cycle with out_stall low.
// A request with a valid sample steps through SUM, START, DIV and FINISH; in
// DIV the serial divider forms the average from the SUMW-bit running sum
// (SUMW = 22 with MAX_WINDOW = 32), one quotient bit per cycle. A reset
// request or a missing sample goes from accept straight to FINISH.
// One request is in work at a time: in_stall is high from accept until the
// result is loaded into the output register, so no new request is taken
// before then. While the receiver stalls, the finished result waits in the
// sequencer and no new request is taken. Configuration is written through
// cfg_write, cfg_index and cfg_data; the user must do so only while idle, as
// the block does not enforce it. Writing the window register clears the
// average history. Reset (rst, synchronous) restores the register defaults,
// the normal state and an empty average; the sample ring is not cleared.
module low_voltage_protector_unit #(
  parameter int MAX_WINDOW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic               sample_valid,
  input  logic signed [15:0] sample_mv,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         protect_state,
  output logic signed [15:0] average_mv,
  output logic               average_valid,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int CNTW  = $clog2(MAX_WINDOW + 1);
  localparam int SLOTW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUMW  = 16 + CNTW;
  localparam logic [8:0] MAXW9 = 9'(MAX_WINDOW);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SUM    = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;

  // configuration
  logic [5:0]         win_cfg;
  lvp_pkg::prot_cfg_t cfg;

  // held request
  logic               req_op;
  logic               req_valid;
  logic signed [15:0] req_mv;
  logic [31:0]        req_now;

  // average history
  logic signed [15:0]      ring [MAX_WINDOW];
  logic signed [15:0]      ring_q;
  logic signed [SUMW-1:0]  running_sum;
  logic [CNTW-1:0]         sample_count;
  logic [SLOTW-1:0]        write_slot;
  logic signed [15:0]      avg;

  logic [CNTW-1:0]         win_eff;
  logic [8:0]              win9;
  logic [8:0]              slot_inc;
  logic                    ring_full;
  logic signed [SUMW-1:0]  sum_next;

  logic                    accept;
  logic                    out_free;
  logic                    div_done;
  logic signed [15:0]      div_quo;
  lvp_pkg::prot_req_t      preq;
  logic [1:0]              mode_next;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // window of 0 acts as 1, anything above the ring depth as the depth
  assign win9 = {3'b000, win_cfg};
  always_comb begin
    if (win_cfg == 6'd0) begin
      win_eff = CNTW'(1);
    end else if (win9 > MAXW9) begin
      win_eff = CNTW'(MAX_WINDOW);
    end else begin
      win_eff = CNTW'(win9);
    end
  end

  assign ring_full = !(sample_count < win_eff);
  assign slot_inc  = 9'(write_slot) + 9'd1;
  assign sum_next  = running_sum + SUMW'(req_mv)
                     - (ring_full ? SUMW'(ring_q) : SUMW'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg                  <= lvp_pkg::RST_WINDOW;
      cfg.stop_threshold_mv    <= lvp_pkg::RST_STOP_THRESHOLD;
      cfg.warn_threshold_mv    <= lvp_pkg::RST_WARN_THRESHOLD;
      cfg.recover_threshold_mv <= lvp_pkg::RST_RECOVER_THRESHOLD;
      cfg.stop_dur_ms          <= lvp_pkg::RST_STOP_DURATION;
      cfg.missing_duration_ms  <= lvp_pkg::RST_MISSING_DURATION;
      cfg.latch_trip           <= lvp_pkg::RST_LATCH_TRIP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lvp_pkg::CFG_WINDOW:            win_cfg <= cfg_data[5:0];
        lvp_pkg::CFG_STOP_THRESHOLD:    cfg.stop_threshold_mv <= cfg_data[15:0];
        lvp_pkg::CFG_WARN_THRESHOLD:    cfg.warn_threshold_mv <= cfg_data[15:0];
        lvp_pkg::CFG_RECOVER_THRESHOLD: cfg.recover_threshold_mv <= cfg_data[15:0];
        lvp_pkg::CFG_STOP_DURATION:     cfg.stop_dur_ms <= cfg_data;
        lvp_pkg::CFG_MISSING_DURATION:  cfg.missing_duration_ms <= cfg_data;
        lvp_pkg::CFG_LATCH_TRIP:        cfg.latch_trip <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (operation == lvp_pkg::OP_UPDATE && sample_valid) state <= ST_SUM;
            else state <= ST_FINISH;
          end
        end
        ST_SUM:    state <= ST_START;
        ST_START:  state <= ST_DIV;
        ST_DIV:    if (div_done) state <= ST_FINISH;
        ST_FINISH: if (out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= operation;
      req_valid <= sample_valid;
      req_mv    <= sample_mv;
      req_now   <= now_ms;
    end
  end

  // ring memory: read the slot about to be overwritten at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_q <= ring[write_slot];
    end
    if (state == ST_SUM) begin
      ring[write_slot] <= req_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      sample_count <= '0;
      write_slot   <= '0;
      avg          <= '0;
    end else if (cfg_write && cfg_index == lvp_pkg::CFG_WINDOW) begin
      running_sum  <= '0;
      sample_count <= '0;
      write_slot   <= '0;
      avg          <= '0;
    end else if (state == ST_SUM) begin
      running_sum <= sum_next;
      if (!ring_full) begin
        sample_count <= sample_count + CNTW'(1);
      end
      if (slot_inc >= 9'(win_eff)) begin
        write_slot <= '0;
      end else begin
        write_slot <= SLOTW'(slot_inc);
      end
    end else if (state == ST_DIV && div_done) begin
      avg <= div_quo;
    end
  end

  lvp_div #(
    .SUMW (SUMW),
    .CNTW (CNTW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_START),
    .dividend (running_sum),
    .divisor  (sample_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    preq.update       = (state == ST_FINISH) && out_free;
    preq.operation    = req_op;
    preq.sample_valid = req_valid;
    preq.now_ms       = req_now;
    preq.have_avg     = (sample_count != '0);
    preq.avg_mv       = avg;
  end

  lvp_prot u_prot (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (preq),
    .mode_next (mode_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (preq.update) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (preq.update) begin
      protect_state <= mode_next;
      average_mv    <= avg;
      average_valid <= preq.have_avg;
    end
  end

endmodule

// ===== sv/lvp_div.sv =====
// Bit-serial restoring divider for the moving average: signed sum over count.
// Truncates toward zero; one quotient bit per cycle. Depends on nothing else.
module lvp_div #(
  parameter int SUMW = 22,
  parameter int CNTW = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [SUMW-1:0] dividend,
  input  logic [CNTW-1:0]        divisor,
  output logic                   done,
  output logic signed [15:0]     quotient
);

  localparam int ITW = $clog2(SUMW + 1);

  logic [SUMW-1:0] quo;
  logic [CNTW-1:0] rem;
  logic [CNTW-1:0] dvs;
  logic [ITW-1:0]  iter;
  logic            neg;
  logic            busy;

  logic [CNTW:0]   trial;
  logic            fits;
  logic [SUMW-1:0] quo_signed;

  assign trial      = {rem, quo[SUMW-1]};
  assign fits       = trial >= {1'b0, dvs};
  assign quo_signed = neg ? (~quo + SUMW'(1)) : quo;
  assign quotient   = quo_signed[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + ITW'(1);
        if (iter == ITW'(SUMW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUMW-1];
      quo <= dividend[SUMW-1] ? (~dividend + SUMW'(1)) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      // shift in the next dividend bit, subtract when the divisor fits
      if (fits) begin
        rem <= CNTW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[CNTW-1:0];
      end
      quo <= {quo[SUMW-2:0], fits};
    end
  end

endmodule

// ===== sv/lvp_prot.sv =====
// Protection state machine with the low-voltage and missing-sample timers.
// Depends on lvp_pkg for the mode codes and the request and config structs.
module lvp_prot (
  input  logic               clk,
  input  logic               rst,
  input  lvp_pkg::prot_cfg_t cfg,
  input  lvp_pkg::prot_req_t req,
  output logic [1:0]         mode_next
);

  logic [1:0]  mode;
  logic        low_run;
  logic [31:0] low_start;
  logic        miss_run;
  logic [31:0] miss_start;

  logic        low_run_next;
  logic [31:0] low_start_next;
  logic        miss_run_next;
  logic [31:0] miss_start_next;
  logic        miss_hit;
  logic        stop_hit;
  logic        below_stop;
  logic        below_warn;
  logic        recovered;
  logic [31:0] miss_elapsed;
  logic [31:0] low_elapsed;

  assign miss_elapsed = req.now_ms - miss_start;
  assign low_elapsed  = req.now_ms - low_start;
  assign below_stop   = req.have_avg && (req.avg_mv < cfg.stop_threshold_mv);
  assign below_warn   = req.have_avg && (req.avg_mv < cfg.warn_threshold_mv);
  assign recovered    = req.have_avg && (req.avg_mv >= cfg.recover_threshold_mv);

  always_comb begin
    mode_next       = mode;
    low_run_next    = low_run;
    low_start_next  = low_start;
    miss_run_next   = miss_run;
    miss_start_next = miss_start;
    miss_hit        = 1'b0;
    stop_hit        = 1'b0;
    if (req.operation == lvp_pkg::OP_RESET) begin
      mode_next       = lvp_pkg::MODE_NORMAL;
      low_run_next    = 1'b0;
      low_start_next  = req.now_ms;
      miss_run_next   = 1'b0;
      miss_start_next = req.now_ms;
    end else begin
      if (!req.sample_valid) begin
        if (!miss_run) begin
          miss_run_next   = 1'b1;
          miss_start_next = req.now_ms;
        end else if (miss_elapsed > cfg.missing_duration_ms) begin
          miss_hit = 1'b1;
        end
      end else begin
        miss_run_next = 1'b0;
      end

      if (below_stop) begin
        if (!low_run) begin
          low_run_next   = 1'b1;
          low_start_next = req.now_ms;
        end else if (low_elapsed > cfg.stop_dur_ms) begin
          stop_hit = 1'b1;
        end
      end else begin
        low_run_next = 1'b0;
      end

      // missing data outranks low voltage
      unique case (mode)
        lvp_pkg::MODE_NORMAL: begin
          if (miss_hit) mode_next = lvp_pkg::MODE_UNAVAILABLE;
          else if (stop_hit) mode_next = lvp_pkg::MODE_TRIPPED;
          else if (below_warn) mode_next = lvp_pkg::MODE_WARNING;
        end
        lvp_pkg::MODE_WARNING: begin
          if (miss_hit) mode_next = lvp_pkg::MODE_UNAVAILABLE;
          else if (stop_hit) mode_next = lvp_pkg::MODE_TRIPPED;
          else if (req.have_avg && !below_warn) mode_next = lvp_pkg::MODE_NORMAL;
        end
        lvp_pkg::MODE_TRIPPED: begin
          if (!cfg.latch_trip && recovered) mode_next = lvp_pkg::MODE_NORMAL;
        end
        default: begin
          if (req.sample_valid && recovered) mode_next = lvp_pkg::MODE_NORMAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= lvp_pkg::MODE_NORMAL;
      low_run    <= 1'b0;
      low_start  <= '0;
      miss_run   <= 1'b0;
      miss_start <= '0;
    end else if (req.update) begin
      mode       <= mode_next;
      low_run    <= low_run_next;
      low_start  <= low_start_next;
      miss_run   <= miss_run_next;
      miss_start <= miss_start_next;
    end
  end

endmodule

// ===== sv/lvp_check.sv =====
// Port-level checker for low_voltage_protector_unit, attached by bind below.
// Depends on the top level's port names only.
module lvp_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         protect_state,
  input logic signed [15:0] average_mv,
  input logic               average_valid
);

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(protect_state)
      && $stable(average_mv) && $stable(average_valid))
    else $error("stalled result changed");

  // one request at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // a new result only follows a request in work
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without request");

  // with no samples averaged the average reads zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !average_valid |-> average_mv == 16'sd0)
    else $error("average without samples");

endmodule

bind low_voltage_protector_unit lvp_check u_lvp_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .protect_state (protect_state),
  .average_mv    (average_mv),
  .average_valid (average_valid)
);
